FILE: rtl/gfmi_pkg.sv
// shared constants and helper functions for the gf(2^m) multiply / invert unit
package gfmi_pkg;

    // field element and polynomial widths
    localparam int ELEM_W = 8;
    localparam int POLY_W = ELEM_W + 1;
    localparam int DIM_W  = $clog2(POLY_W + 1);

    // largest field dimension handled, larger degrees act as dimension zero
    localparam int MAX_DIM = 8;

    // polynomial after reset: x^8 + x^4 + x^3 + x + 1
    localparam logic [POLY_W-1:0] POLY_RESET = 9'h11B;

    // command codes
    localparam logic CMD_MUL = 1'b0;
    localparam logic CMD_INV = 1'b1;

    // degree of the reduction polynomial, clamped to zero above MAX_DIM
    function automatic logic [DIM_W-1:0] poly_degree(input logic [POLY_W-1:0] poly);
        logic [DIM_W-1:0] d;
        d = '0;
        for (int k = 1; k < POLY_W; k++) begin
            if (poly[k]) begin
                d = DIM_W'(k);
            end
        end
        if (d > DIM_W'(MAX_DIM)) begin
            d = '0;
        end
        return d;
    endfunction

    // mask of the bits below the field dimension
    function automatic logic [ELEM_W-1:0] dim_mask(input logic [DIM_W-1:0] dim);
        logic [POLY_W-1:0] c;
        c = (POLY_W'(1) << dim) - POLY_W'(1);
        return c[ELEM_W-1:0];
    endfunction

endpackage

FILE: rtl/gf2m_multiply_invert.sv
// top level: gf(2^m) multiply and invert unit with programmable polynomial
//
// usage:
//   request channel: drive i_command, i_operand_a, i_operand_b and raise start;
//   the request is taken at a clock edge where start is high and busy is low.
//   command 0 multiplies a by b, command 1 inverts a. operand bits at or above
//   the field dimension m (degree of the polynomial) are ignored.
//   result channel: o_done is high for exactly one cycle with o_result_value
//   and o_no_inverse; the receiver cannot stall, so the result must be taken
//   in that cycle. busy is already low in that cycle, so a new request may
//   follow at once.
//   configuration: i_cfg_field_poly is written when i_cfg_valid and
//   o_cfg_ready are both high; o_cfg_ready is high while the unit is idle
//   and no request is being raised on start.
//   sequencing: a multiply passes through S_MUL, where the product is registered
//   with o_done. invert walks the candidates 1 .. 2^m-1 through the single
//   shared field multiplier, one per cycle, up to 255 candidates for m = 8; the
//   multiplier is the limit. invert of zero ends in its first step with zero.
//   reset: synchronous, active low; the polynomial returns to 0x11B and any
//   request in flight is dropped without a result.
module gf2m_multiply_invert (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_command,
    input  logic [gfmi_pkg::ELEM_W-1:0]  i_operand_a,
    input  logic [gfmi_pkg::ELEM_W-1:0]  i_operand_b,
    output logic                         o_done,
    output logic [gfmi_pkg::ELEM_W-1:0]  o_result_value,
    output logic                         o_no_inverse,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [gfmi_pkg::POLY_W-1:0]  i_cfg_field_poly
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_INV
    } t_state;

    t_state                      r_state;
    logic                        r_done;
    logic [gfmi_pkg::POLY_W-1:0] r_poly;
    logic                        r_cmd;
    logic [gfmi_pkg::ELEM_W-1:0] r_a;
    logic [gfmi_pkg::ELEM_W-1:0] r_b;
    logic [gfmi_pkg::ELEM_W-1:0] r_result;
    logic                        r_no_inv;

    logic [gfmi_pkg::DIM_W-1:0]  dim;
    logic [gfmi_pkg::ELEM_W-1:0] mask;
    logic [gfmi_pkg::ELEM_W-1:0] product;
    logic                        accept;

    // field dimension and element mask from the polynomial
    assign dim    = gfmi_pkg::poly_degree(r_poly);
    assign mask   = gfmi_pkg::dim_mask(dim);
    assign accept = start && (r_state == S_IDLE);

    // shared multiplier; r_b is the multiplicand or the inverse candidate
    gfmi_mul u_mul (
        .i_a       (r_a),
        .i_b       (r_b),
        .i_poly    (r_poly),
        .i_dim     (dim),
        .i_mask    (mask),
        .o_product (product)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= gfmi_pkg::POLY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_poly <= i_cfg_field_poly;
        end
    end

    // sequencer, operand registers and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd <= i_command;
                        r_a   <= i_operand_a & mask;
                        if (i_command == gfmi_pkg::CMD_INV) begin
                            r_b     <= gfmi_pkg::ELEM_W'(1);
                            r_state <= S_INV;
                        end else begin
                            r_b     <= i_operand_b & mask;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_result <= product;
                    r_no_inv <= 1'b0;
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_INV: begin
                    if (r_a == '0) begin
                        // zero maps to zero
                        r_result <= '0;
                        r_no_inv <= 1'b0;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (product == gfmi_pkg::ELEM_W'(1)) begin
                        r_result <= r_b;
                        r_no_inv <= 1'b0;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_b == mask) begin
                        // every candidate tried, no inverse exists
                        r_result <= '0;
                        r_no_inv <= 1'b1;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_b <= r_b + gfmi_pkg::ELEM_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // outputs; a request raised in the same cycle wins over a polynomial write
    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE) && !start;
    assign o_done         = r_done;
    assign o_result_value = r_result;
    assign o_no_inverse   = r_no_inv;

    // a result is only shown once the sequencer is back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer busy");

    // an accepted request keeps the unit busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start the sequencer");

    // the missing-inverse flag only comes from an invert and carries a zero value
    a_flag_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_no_inverse) |->
            (r_cmd == gfmi_pkg::CMD_INV) && (o_result_value == '0))
        else $error("no_inverse raised on a multiply or with nonzero value");

    // the inverse candidate stays within 1 .. 2^m-1
    a_cand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INV && r_a != '0) |-> (r_b != '0) && (r_b <= mask))
        else $error("inverse candidate out of range");

endmodule

FILE: rtl/gfmi_mul.sv
// shift-and-xor field multiplier with programmable reduction, one product per cycle
module gfmi_mul (
    input  logic [gfmi_pkg::ELEM_W-1:0] i_a,
    input  logic [gfmi_pkg::ELEM_W-1:0] i_b,
    input  logic [gfmi_pkg::POLY_W-1:0] i_poly,
    input  logic [gfmi_pkg::DIM_W-1:0]  i_dim,
    input  logic [gfmi_pkg::ELEM_W-1:0] i_mask,
    output logic [gfmi_pkg::ELEM_W-1:0] o_product
);

    // one partial product and one reduction per bit below the dimension
    always_comb begin
        logic [gfmi_pkg::ELEM_W-1:0] acc;
        logic [gfmi_pkg::POLY_W-1:0] y;
        logic [gfmi_pkg::POLY_W-1:0] y_sh;
        acc  = '0;
        y_sh = '0;
        y    = {1'b0, i_b & i_mask};
        for (int k = 0; k < gfmi_pkg::ELEM_W; k++) begin
            if (gfmi_pkg::DIM_W'(k) < i_dim) begin
                if (i_a[k]) begin
                    acc = acc ^ y[gfmi_pkg::ELEM_W-1:0];
                end
                y_sh = {y[gfmi_pkg::POLY_W-2:0], 1'b0};
                // reduce when the shifted value reaches bit m
                if (|(y_sh & ~{1'b0, i_mask})) begin
                    y_sh = y_sh ^ i_poly;
                end
                y = y_sh;
            end
        end
        o_product = acc & i_mask;
    end

endmodule
